### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the RGB to HSV converter.
// Depends on nothing; every user supplies clk and rst_n in its own scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RHSV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RHSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rhsv_pkg.sv
// Package for the RGB to HSV converter: constants, lane types, hue offset lookup.
// No dependencies.
`default_nettype none

package rhsv_pkg;

    localparam int unsigned DIV_STEPS = 8;

    localparam logic [7:0] FULL_SCALE     = 8'd255;
    localparam logic [7:0] HUE_STEP       = 8'd43;
    localparam logic [7:0] HUE_BASE_RED   = 8'd0;
    localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
    localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;

    typedef enum logic [1:0] {
        CH_RED   = 2'b00,
        CH_GREEN = 2'b01,
        CH_BLUE  = 2'b10
    } chan_t;

    // Per-pixel information carried alongside the divider lanes.
    typedef struct packed {
        logic [7:0] mx;
        logic       neg;
        chan_t      sel;
        logic       flat;
    } side_t;

    // One pixel in flight through the divider: two restoring divisions side by side.
    typedef struct packed {
        logic [15:0] sat_num;
        logic [15:0] hue_num;
        logic [7:0]  sat_rem;
        logic [7:0]  hue_rem;
        logic [7:0]  sat_q;
        logic [7:0]  hue_q;
        logic [7:0]  span;
        side_t       side;
    } div_lane_t;

    function automatic logic [7:0] hue_base(input chan_t sel);
        logic [7:0] base;
        unique case (sel)
            CH_RED:   base = HUE_BASE_RED;
            CH_GREEN: base = HUE_BASE_GREEN;
            CH_BLUE:  base = HUE_BASE_BLUE;
            default:  base = HUE_BASE_RED;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rhsv_div.sv
// Pipelined restoring divider: one quotient bit per stage for saturation and hue.
// Depends on rhsv_pkg.
`default_nettype none

module rhsv_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rhsv_pkg::div_lane_t in_lane,
    output logic                out_valid,
    input  logic                out_ready,
    output rhsv_pkg::div_lane_t out_lane
);
    import rhsv_pkg::*;

    // Shift in one numerator bit, subtract the divisor if it fits.
    function automatic div_lane_t div_step(input div_lane_t l, input logic [2:0] pos);
        div_lane_t  o;
        logic [8:0] sat_t;
        logic [8:0] hue_t;
        o     = l;
        sat_t = {l.sat_rem, l.sat_num[pos]};
        hue_t = {l.hue_rem, l.hue_num[pos]};
        if (sat_t >= {1'b0, l.side.mx})
        begin
            o.sat_rem      = 8'(sat_t - {1'b0, l.side.mx});
            o.sat_q[pos]   = 1'b1;
        end
        else
        begin
            o.sat_rem = sat_t[7:0];
        end
        if (hue_t >= {1'b0, l.span})
        begin
            o.hue_rem      = 8'(hue_t - {1'b0, l.span});
            o.hue_q[pos]   = 1'b1;
        end
        else
        begin
            o.hue_rem = hue_t[7:0];
        end
        return o;
    endfunction

    logic      valid_reg [DIV_STEPS];
    div_lane_t lane_reg  [DIV_STEPS];
    logic      adv       [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        localparam logic [2:0] POS = 3'(DIV_STEPS - 1 - k);
        div_lane_t src;
        logic      src_valid;
        div_lane_t lane_next;

        if (k == 0)
        begin : g_first
            assign src       = in_lane;
            assign src_valid = in_valid;
        end
        else
        begin : g_mid
            assign src       = lane_reg[k-1];
            assign src_valid = valid_reg[k-1];
        end

        // Advance when this stage is empty or the next one moves.
        if (k == DIV_STEPS - 1)
        begin : g_last_adv
            assign adv[k] = ~valid_reg[k] | out_ready;
        end
        else
        begin : g_mid_adv
            assign adv[k] = ~valid_reg[k] | adv[k+1];
        end

        assign lane_next = div_step(src, POS);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (adv[k])
                valid_reg[k] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && src_valid)
                lane_reg[k] <= lane_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_lane  = lane_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

### rtl/core/rgb_to_hsv_8bit_top.sv
// Top level of the 8-bit RGB to HSV pixel converter.
// Depends on rhsv_pkg and rhsv_div.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | sink      | in_valid/in_stall  | red, green, blue
//  out     | source    | out_valid/out_stall| hue, saturation, brightness
//
// One pixel per clock sustained while out_stall stays low; each transaction passes
// in order through the range stage, numerator stage, eight divider stages (one quotient
// bit each, both divisions in parallel), and the output stage.
// Reset clears only the valid bits; payload registers are not reset.
// A stall on the output backs up stage by stage; empty stages keep filling, so
// bubbles are squeezed out and in_stall rises only when every stage holds a pixel.
`default_nettype none

module rgb_to_hsv_8bit_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] hue,
    output logic [7:0] saturation,
    output logic [7:0] brightness
);
    import rhsv_pkg::*;

    // ---------------------------------------------------------------
    // Stage A: max, min, dominant channel and signed hue difference
    // ---------------------------------------------------------------
    logic       a_valid_reg;
    side_t      a_side_reg;
    logic [7:0] a_span_reg;
    logic [7:0] a_mag_reg;

    side_t      a_side_next;
    logic [7:0] a_span_next;
    logic [7:0] a_mag_next;
    logic [7:0] mn;
    logic [7:0] hi;
    logic [7:0] lo;

    logic       en_a;
    logic       en_b;
    logic       en_o;

    always_comb
    begin
        a_side_next = '0;
        // Ties go to red first, then green.
        priority if (red >= green && red >= blue)
        begin
            a_side_next.sel = CH_RED;
            a_side_next.mx  = red;
            hi              = green;
            lo              = blue;
        end
        else if (green >= blue)
        begin
            a_side_next.sel = CH_GREEN;
            a_side_next.mx  = green;
            hi              = blue;
            lo              = red;
        end
        else
        begin
            a_side_next.sel = CH_BLUE;
            a_side_next.mx  = blue;
            hi              = red;
            lo              = green;
        end
        mn = (red < green) ? red : green;
        if (blue < mn)
            mn = blue;
        a_side_next.neg = (hi < lo);
        a_mag_next      = a_side_next.neg ? 8'(lo - hi) : 8'(hi - lo);
        a_span_next     = 8'(a_side_next.mx - mn);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en_a)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
        begin
            a_side_reg <= a_side_next;
            a_span_reg <= a_span_next;
            a_mag_reg  <= a_mag_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage B: constant multiplies into the two numerators
    // ---------------------------------------------------------------
    logic      b_valid_reg;
    div_lane_t b_lane_reg;
    div_lane_t b_lane_next;

    always_comb
    begin
        b_lane_next           = '0;
        b_lane_next.sat_num   = 16'(a_span_reg) * 16'(FULL_SCALE);
        b_lane_next.hue_num   = 16'(a_mag_reg) * 16'(HUE_STEP);
        // Both quotients fit in 8 bits, so the upper byte starts below the divisor.
        b_lane_next.sat_rem   = b_lane_next.sat_num[15:8];
        b_lane_next.hue_rem   = b_lane_next.hue_num[15:8];
        b_lane_next.span      = a_span_reg;
        b_lane_next.side      = a_side_reg;
        // Gray or black pixel: hue and saturation forced to zero at the end.
        b_lane_next.side.flat = (a_span_reg == 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en_b)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_b && a_valid_reg)
            b_lane_reg <= b_lane_next;
    end

    // ---------------------------------------------------------------
    // Divider pipeline
    // ---------------------------------------------------------------
    logic      div_in_ready;
    logic      div_out_valid;
    div_lane_t div_out_lane;

    rhsv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .in_ready  (div_in_ready),
        .in_lane   (b_lane_reg),
        .out_valid (div_out_valid),
        .out_ready (en_o),
        .out_lane  (div_out_lane)
    );

    // ---------------------------------------------------------------
    // Output stage: apply sign and hue offset, wrap modulo 256
    // ---------------------------------------------------------------
    logic       out_valid_reg;
    logic [7:0] hue_reg;
    logic [7:0] saturation_reg;
    logic [7:0] brightness_reg;
    logic [7:0] hue_next;
    logic [7:0] saturation_next;
    logic [7:0] hue_term;

    always_comb
    begin
        hue_term = div_out_lane.side.neg ? 8'(8'd0 - div_out_lane.hue_q)
                                         : div_out_lane.hue_q;
        if (div_out_lane.side.flat)
        begin
            hue_next        = 8'd0;
            saturation_next = 8'd0;
        end
        else
        begin
            hue_next        = 8'(hue_base(div_out_lane.side.sel) + hue_term);
            saturation_next = div_out_lane.sat_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_o)
            out_valid_reg <= div_out_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en_o && div_out_valid)
        begin
            hue_reg        <= hue_next;
            saturation_reg <= saturation_next;
            brightness_reg <= div_out_lane.side.mx;
        end
    end

    // Advance a stage when it is empty or its successor advances.
    assign en_o = ~out_valid_reg | ~out_stall;
    assign en_b = ~b_valid_reg | div_in_ready;
    assign en_a = ~a_valid_reg | en_b;

    assign in_stall   = ~en_a;
    assign out_valid  = out_valid_reg;
    assign hue        = hue_reg;
    assign saturation = saturation_reg;
    assign brightness = brightness_reg;

endmodule

`default_nettype wire

### rtl/core/rhsv_checker.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rhsv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] hue,
    input logic [7:0] saturation,
    input logic [7:0] brightness
);

    logic        in_busy;
    logic        out_busy;
    logic [23:0] in_word;
    logic [23:0] out_word;
    logic        hs_zero;

    assign in_busy  = in_valid && in_stall;
    assign out_busy = out_valid && out_stall;
    assign in_word  = {red, green, blue};
    assign out_word = {hue, saturation, brightness};
    assign hs_zero  = (hue == 8'd0) && (saturation == 8'd0);

    // Hold a stalled input transaction unchanged.
    `RHSV_ASSERT_NEXT(a_in_hold, in_busy, in_valid && $stable(in_word), "input changed")

    // Hold a stalled result unchanged.
    `RHSV_ASSERT_NEXT(a_out_hold, out_busy, out_valid && $stable(out_word), "result changed")

    // Backpressure only ever comes from a stalled, full output.
    `RHSV_ASSERT_NOW(a_stall_source, in_stall, out_busy, "input stalled without output stall")

    // Black pixel: no hue, no saturation.
    `RHSV_ASSERT_NOW(a_black, out_valid && brightness == 8'd0, hs_zero, "black pixel colored")

    // Zero saturation means a gray pixel, whose hue is zero.
    `RHSV_ASSERT_NOW(a_gray, out_valid && saturation == 8'd0, hue == 8'd0, "gray with hue")

endmodule

bind rgb_to_hsv_8bit_top rhsv_checker u_rhsv_checker (.*);

`default_nettype wire

### tb/tb.sv
// Testbench for rgb_to_hsv_8bit_top: a directed pixel table, then random pixels, with
// random gaps and stalls on both channels, scored against typed results or a behavioral HSV predictor.
// Depends on rhsv_pkg (channel enum) and the converter RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhsv_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_PIXELS   = 1000;
    // The pipeline is 11 stages deep; wait well past it before the final verdict.
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int FIRST_HOLD_AT   = 150;
    localparam int HOLD_SPACING    = 450;
    localparam int MAX_REPORTS     = 10;

    // Integer HSV scheme constants.
    localparam int SAT_SCALE    = 255;
    localparam int HUE_SECTOR   = 43;
    localparam int GREEN_OFFSET = 85;
    localparam int BLUE_OFFSET  = 171;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } hsv_t;

    // One row of the directed table. Rows with known set carry a hand-typed result;
    // the rest are scored against the predictor.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       known;
        hsv_t       want;
    } pixel_case_t;

    localparam int N_DIRECTED = 22;
    localparam pixel_case_t DIRECTED [N_DIRECTED] = '{
        // black, white and grays: hue and saturation stay zero
        '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{8'd128, 8'd128, 8'd128, 1'b1, '{8'd0,   8'd0,   8'd128}},
        '{8'd1,   8'd1,   8'd1,   1'b1, '{8'd0,   8'd0,   8'd1  }},
        // primaries land on the sector offsets
        '{8'd255, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd255}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{8'd85,  8'd255, 8'd255}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{8'd171, 8'd255, 8'd255}},
        // ties: red wins over green, green over blue
        '{8'd255, 8'd255, 8'd0,   1'b1, '{8'd43,  8'd255, 8'd255}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{8'd128, 8'd255, 8'd255}},
        // magenta: negative hue term wraps to 256 - 43
        '{8'd255, 8'd0,   8'd255, 1'b1, '{8'd213, 8'd255, 8'd255}},
        // smallest nonzero brightness
        '{8'd1,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd1  }},
        '{8'd0,   8'd0,   8'd1,   1'b1, '{8'd171, 8'd255, 8'd1  }},
        // smallest nonzero span at full brightness
        '{8'd255, 8'd254, 8'd254, 1'b1, '{8'd0,   8'd1,   8'd255}},
        // negative term in each sector, and assorted interior points
        '{8'd255, 8'd0,   8'd128, 1'b0, '0},
        '{8'd100, 8'd255, 8'd0,   1'b0, '0},
        '{8'd0,   8'd100, 8'd255, 1'b0, '0},
        '{8'd200, 8'd50,  8'd100, 1'b0, '0},
        '{8'd10,  8'd200, 8'd150, 1'b0, '0},
        '{8'd170, 8'd85,  8'd255, 1'b0, '0},
        '{8'd254, 8'd255, 8'd253, 1'b0, '0},
        '{8'd255, 8'd1,   8'd0,   1'b0, '0},
        '{8'd127, 8'd128, 8'd129, 1'b0, '0}
    };

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [7:0] red        = 8'd0;
    logic [7:0] green      = 8'd0;
    logic [7:0] blue       = 8'd0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;

    hsv_t hsv_pending[$];      // predicted pixels, oldest first
    int   mismatch_count = 0;
    int   pixels_out     = 0;
    bit   burst_in       = 1'b0;

    rgb_to_hsv_8bit_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    initial
    begin : clock_gen
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Integer HSV of one pixel: value is the top channel, saturation is a truncated quotient
    // over the value and hue one over the span, hue wraps modulo 256.
    function automatic hsv_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        int    ri, gi, bi, mx, mn, span, hi, lo, base, mag;
        chan_t top_ch;
        hsv_t  res;
        ri = r;
        gi = g;
        bi = b;
        mx = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        mn = ri;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        span = mx - mn;
        res.val = mx[7:0];
        res.hue = 8'd0;
        res.sat = 8'd0;
        if (mx != 0 && span != 0)
        begin
            res.sat = 8'((SAT_SCALE * span) / mx);
            if (mx == ri)
                top_ch = CH_RED;
            else if (mx == gi)
                top_ch = CH_GREEN;
            else
                top_ch = CH_BLUE;
            case (top_ch)
                CH_RED:
                begin
                    base = 0;
                    hi = gi;
                    lo = bi;
                end
                CH_GREEN:
                begin
                    base = GREEN_OFFSET;
                    hi = bi;
                    lo = ri;
                end
                default:
                begin
                    base = BLUE_OFFSET;
                    hi = ri;
                    lo = gi;
                end
            endcase
            // truncate the magnitude, then apply the sign
            if (hi >= lo)
            begin
                mag = (HUE_SECTOR * (hi - lo)) / span;
                res.hue = 8'(base + mag);
            end
            else
            begin
                mag = (HUE_SECTOR * (lo - hi)) / span;
                res.hue = 8'(base - mag);
            end
        end
        return res;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    // Burst mode forces back-to-back traffic.
    function automatic int pick_gap(input bit burst);
        int roll;
        if (burst)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Random pixel, biased toward grays, ties on the top channel, rail values,
    // tiny values and near-gray pixels where the span is at most three.
    task automatic pick_pixel(output logic [7:0] r, output logic [7:0] g,
                              output logic [7:0] b);
        logic [7:0] a, c;
        a = 8'($urandom_range(1, 255));
        c = 8'($urandom_range(0, a - 1));
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(0, 9))
            5:
            begin
                g = r;
                b = r;
            end
            6:
            begin
                case ($urandom_range(0, 2))
                    0:       {r, g, b} = {a, a, c};
                    1:       {r, g, b} = {a, c, a};
                    default: {r, g, b} = {c, a, a};
                endcase
            end
            7:
            begin
                a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                case ($urandom_range(0, 2))
                    0:       r = a;
                    1:       g = a;
                    default: b = a;
                endcase
            end
            8:
            begin
                r = 8'($urandom_range(0, 3));
                g = 8'($urandom_range(0, 3));
                b = 8'($urandom_range(0, 3));
            end
            9:
            begin
                g = r ^ 8'($urandom_range(0, 3));
                b = r ^ 8'($urandom_range(0, 3));
            end
            default: ;
        endcase
    endtask

    // Offer one pixel, starting at a falling edge. Optionally drop valid for a gap,
    // then hold the payload until the rising edge that takes the transaction, and
    // queue its prediction. Returns at the next falling edge with valid still high.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic known, input hsv_t typed);
        int gap;
        gap = pick_gap(burst_in);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hsv_pending.push_back(known ? typed : convert_pixel(r, g, b));
        @(negedge clk);
    endtask

    // Sender side: reset, directed table, random pixels, then drain and report.
    initial
    begin : stimulus
        logic [7:0] pr, pg, pb;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_pixel(DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b,
                       DIRECTED[i].known, DIRECTED[i].want);

        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            // switch between gapped traffic and back-to-back bursts now and then
            if (n % 50 == 0)
                burst_in = ($urandom_range(0, 3) == 0);
            pick_pixel(pr, pg, pb);
            send_pixel(pr, pg, pb, 1'b0, '0);
        end
        in_valid <= 1'b0;

        // Wait for every predicted pixel, then linger to catch any stray output.
        while (hsv_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && hsv_pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Receiver side: random stall runs, burst stretches with no stall, and a long
    // hold-off from time to time so the pipeline fills and pushes back on the input.
    initial
    begin : drive_out_stall
        int stall_left;
        int next_hold;
        int cycle_n;
        bit burst_out;
        stall_left = 0;
        next_hold  = FIRST_HOLD_AT;
        cycle_n    = 0;
        burst_out  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cycle_n++;
            if (cycle_n % 64 == 0)
                burst_out = ($urandom_range(0, 3) == 0);
            if (pixels_out >= next_hold)
            begin
                stall_left = HOLD_OFF_CYCLES;
                next_hold += HOLD_SPACING;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap(burst_out);
            end
        end
    end

    // Score every output transaction against the oldest prediction.
    always @(posedge clk)
    begin : score_output
        hsv_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            pixels_out++;
            if (hsv_pending.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected output: hue %0d sat %0d val %0d",
                             hue, saturation, brightness);
            end
            else
            begin
                want = hsv_pending.pop_front();
                if (hue !== want.hue || saturation !== want.sat ||
                    brightness !== want.val)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("pixel %0d: expected h/s/v %0d/%0d/%0d, got %0d/%0d/%0d",
                                 pixels_out, want.hue, want.sat, want.val,
                                 hue, saturation, brightness);
                end
            end
        end
    end

    // Watchdog: abort a hung run.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/rhsv_pkg.sv
rtl/core/rhsv_div.sv
rtl/core/rgb_to_hsv_8bit_top.sv
rtl/core/rhsv_checker.sv
tb/tb.sv
